/* hdl/etl_pkg.sv */
// Shared types and constants of the expression token lexer.
// No dependencies; every other file of the block refers to it by scoped names.
package etl_pkg;

  localparam int MAX_EXPR_LEN_DEF = 4096;
  localparam int CHAR_W           = 8;
  localparam int POS_W            = 12;
  localparam int CLS_W            = 4;
  localparam int CMP_W            = 3;
  localparam int QUEUE_DEPTH      = 4;

  // token classes
  localparam logic [CLS_W-1:0] CLS_STOP     = 4'd0;
  localparam logic [CLS_W-1:0] CLS_DELIM    = 4'd1;
  localparam logic [CLS_W-1:0] CLS_OPERATOR = 4'd2;
  localparam logic [CLS_W-1:0] CLS_COMPARE  = 4'd3;
  localparam logic [CLS_W-1:0] CLS_NUMBER   = 4'd4;
  localparam logic [CLS_W-1:0] CLS_FUNCTION = 4'd5;
  localparam logic [CLS_W-1:0] CLS_LOGICAL  = 4'd6;
  localparam logic [CLS_W-1:0] CLS_VARIABLE = 4'd7;
  localparam logic [CLS_W-1:0] CLS_UNKNOWN  = 4'd8;

  // compare codes
  localparam logic [CMP_W-1:0] CMP_NONE = 3'd0;
  localparam logic [CMP_W-1:0] CMP_EQ   = 3'd1;
  localparam logic [CMP_W-1:0] CMP_GT   = 3'd2;
  localparam logic [CMP_W-1:0] CMP_LT   = 3'd3;
  localparam logic [CMP_W-1:0] CMP_NE   = 3'd4;
  localparam logic [CMP_W-1:0] CMP_LE   = 3'd5;
  localparam logic [CMP_W-1:0] CMP_GE   = 3'd6;

  typedef struct packed {
    logic [CLS_W-1:0]  token_class;
    logic [CHAR_W-1:0] operator_char;
    logic [CMP_W-1:0]  compare_code;
    logic              logical_is_or;
    logic [POS_W-1:0]  token_start;
    logic [POS_W-1:0]  token_length;
  } tok_t;

  // Tokens caused by one character; tok1 is meaningful only when two is set.
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } entry_t;

endpackage

/* hdl/etl_intf.sv */
// Channel interfaces of the expression token lexer: character input and token output.
// Depends on etl_pkg for field widths.
interface etl_in_if;
  logic                        valid;
  logic                        ready;
  logic [etl_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface etl_out_if;
  logic                        valid;
  logic                        ready;
  logic [etl_pkg::CLS_W-1:0]   token_class;
  logic [etl_pkg::CHAR_W-1:0]  operator_char;
  logic [etl_pkg::CMP_W-1:0]   compare_code;
  logic                        logical_is_or;
  logic [etl_pkg::POS_W-1:0]   token_start;
  logic [etl_pkg::POS_W-1:0]   token_length;
  logic                        last_of_run;

  modport source (output valid, output token_class, output operator_char,
                  output compare_code, output logical_is_or, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_class, input operator_char,
                  input compare_code, input logical_is_or, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

/* hdl/etl_front.sv */
// Front end: accepts one character per cycle while the queue has room, keeps the lexer
// state and forms the zero, one or two tokens each character causes. Depends on etl_pkg.
module etl_front #(
  parameter int MAX_EXPR_LEN = etl_pkg::MAX_EXPR_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [etl_pkg::CHAR_W-1:0] in_char_code,
  output logic                       in_ready,
  output logic                       push_valid,
  output etl_pkg::entry_t            push_entry,
  input  logic                       push_ready
);

  localparam int PW = etl_pkg::POS_W;
  localparam int POS_MAX = (1 << PW) - 1;
  localparam logic [PW-1:0] POS_CAP =
    ((MAX_EXPR_LEN - 1) < POS_MAX) ? PW'(MAX_EXPR_LEN - 1) : PW'(POS_MAX);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CMP  = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_ID   = 2'd3;

  localparam logic [1:0] FC_EQ = 2'd0;
  localparam logic [1:0] FC_LT = 2'd1;
  localparam logic [1:0] FC_GT = 2'd2;

  localparam logic [2:0] KW_EMPTY = 3'd0;
  localparam logic [2:0] KW_A     = 3'd1;
  localparam logic [2:0] KW_AN    = 3'd2;
  localparam logic [2:0] KW_AND   = 3'd3;
  localparam logic [2:0] KW_O     = 3'd4;
  localparam logic [2:0] KW_OR    = 3'd5;
  localparam logic [2:0] KW_NONE  = 3'd7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LD     = 8'h64;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LO     = 8'h6F;
  localparam logic [7:0] CH_LR     = 8'h72;

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] ch);
    return ((ch >= 8'h41) && (ch <= 8'h5A)) ? (ch | 8'h20) : ch;
  endfunction

  function automatic logic is_op(input logic [7:0] ch);
    return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH) ||
           (ch == CH_LPAREN) || (ch == CH_RPAREN) || (ch == CH_LBRACE) ||
           (ch == CH_RBRACE) || (ch == CH_CARET);
  endfunction

  function automatic logic [2:0] kw_next(input logic [2:0] k, input logic [7:0] lc);
    logic [2:0] res;
    res = KW_NONE;
    if ((k == KW_A) && (lc == CH_LN)) res = KW_AN;
    if ((k == KW_AN) && (lc == CH_LD)) res = KW_AND;
    if ((k == KW_O) && (lc == CH_LR)) res = KW_OR;
    return res;
  endfunction

  // end minus start, floored at zero and capped
  function automatic logic [PW-1:0] span(input logic [PW:0] e, input logic [PW-1:0] s);
    logic [PW:0] d;
    d = (e >= {1'b0, s}) ? (e - {1'b0, s}) : '0;
    return (d > {1'b0, POS_CAP}) ? POS_CAP : d[PW-1:0];
  endfunction

  logic [1:0]    mode_r, mode_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] start_r, start_nxt;
  logic [1:0]    pfc_r, pfc_nxt;
  logic [2:0]    kw_r, kw_nxt;

  logic [7:0]       c;
  logic [7:0]       lc;
  logic             adv;
  logic             f_v, n_v;
  etl_pkg::tok_t    f_tok, n_tok;
  logic [PW:0]      pos_p1;
  logic             acc;

  always_comb begin
    c         = (in_char_code == CH_COMMA) ? CH_PERIOD : in_char_code;
    lc        = to_lower(c);
    pos_p1    = {1'b0, pos_r} + 1'b1;
    mode_nxt  = mode_r;
    start_nxt = start_r;
    pfc_nxt   = pfc_r;
    kw_nxt    = kw_r;
    adv       = 1'b0;
    f_v       = 1'b0;
    n_v       = 1'b0;
    f_tok     = '0;
    n_tok     = '0;
    pos_nxt   = pos_r;

    if ((mode_r == MODE_CMP) && ((c == CH_GT) || (c == CH_EQ))) begin
      // second character of a two-character compare
      n_v                = 1'b1;
      n_tok.token_class  = etl_pkg::CLS_COMPARE;
      n_tok.token_start  = start_r;
      n_tok.token_length = span(pos_p1, start_r);
      case (pfc_r)
        FC_LT:   n_tok.compare_code = (c == CH_GT) ? etl_pkg::CMP_NE : etl_pkg::CMP_LE;
        FC_GT:   n_tok.compare_code = (c == CH_EQ) ? etl_pkg::CMP_GE : etl_pkg::CMP_NONE;
        default: n_tok.compare_code = etl_pkg::CMP_NONE;
      endcase
      mode_nxt = MODE_IDLE;
      adv      = 1'b1;
    end else if ((mode_r == MODE_NUM) && (is_digit(c) || (c == CH_PERIOD))) begin
      adv = 1'b1;
    end else if ((mode_r == MODE_ID) &&
                 (is_letter(c) || is_digit(c) || (c == CH_USCORE) || (c == CH_PERIOD))) begin
      kw_nxt = kw_next(kw_r, lc);
      adv    = 1'b1;
    end else if ((mode_r == MODE_ID) && ((c == CH_LPAREN) || (c == CH_LBRACE))) begin
      // identifier runs into a brace: function, brace included
      n_v                = 1'b1;
      n_tok.token_class  = etl_pkg::CLS_FUNCTION;
      n_tok.token_start  = start_r;
      n_tok.token_length = span(pos_p1, start_r);
      mode_nxt           = MODE_IDLE;
      adv                = 1'b1;
    end else begin
      // drop out of any pending token first
      if (mode_r != MODE_IDLE) begin
        f_v                = 1'b1;
        f_tok.token_start  = start_r;
        f_tok.token_length = span({1'b0, pos_r}, start_r);
        case (mode_r)
          MODE_CMP: begin
            f_tok.token_class  = etl_pkg::CLS_COMPARE;
            f_tok.compare_code = (pfc_r == FC_LT) ? etl_pkg::CMP_LT :
                                 (pfc_r == FC_GT) ? etl_pkg::CMP_GT : etl_pkg::CMP_EQ;
          end
          MODE_NUM: begin
            f_tok.token_class = etl_pkg::CLS_NUMBER;
          end
          default: begin
            if (kw_r == KW_AND) begin
              f_tok.token_class = etl_pkg::CLS_LOGICAL;
            end else if (kw_r == KW_OR) begin
              f_tok.token_class   = etl_pkg::CLS_LOGICAL;
              f_tok.logical_is_or = 1'b1;
            end else begin
              f_tok.token_class = etl_pkg::CLS_VARIABLE;
            end
          end
        endcase
        mode_nxt = MODE_IDLE;
      end

      if (c == CH_NUL) begin
        n_v                = 1'b1;
        n_tok.token_class  = etl_pkg::CLS_STOP;
        n_tok.token_start  = pos_r;
        mode_nxt           = MODE_IDLE;
        start_nxt          = '0;
        pfc_nxt            = FC_EQ;
        kw_nxt             = KW_EMPTY;
      end else begin
        adv = 1'b1;
        if ((c == CH_SPACE) || (c == CH_TAB)) begin
          n_v = 1'b0;
        end else if (c == CH_SEMI) begin
          n_v                 = 1'b1;
          n_tok.token_class   = etl_pkg::CLS_DELIM;
          n_tok.operator_char = c;
          n_tok.token_start   = pos_r;
          n_tok.token_length  = PW'(1);
        end else if (is_op(c)) begin
          n_v                 = 1'b1;
          n_tok.token_class   = etl_pkg::CLS_OPERATOR;
          n_tok.operator_char = c;
          n_tok.token_start   = pos_r;
          n_tok.token_length  = PW'(1);
        end else if ((c == CH_EQ) || (c == CH_LT) || (c == CH_GT)) begin
          mode_nxt  = MODE_CMP;
          start_nxt = pos_r;
          pfc_nxt   = (c == CH_LT) ? FC_LT : (c == CH_GT) ? FC_GT : FC_EQ;
        end else if (is_digit(c)) begin
          mode_nxt  = MODE_NUM;
          start_nxt = pos_r;
        end else if (is_letter(c)) begin
          mode_nxt  = MODE_ID;
          start_nxt = pos_r;
          kw_nxt    = (lc == CH_LA) ? KW_A : (lc == CH_LO) ? KW_O : KW_NONE;
        end else begin
          n_v                = 1'b1;
          n_tok.token_class  = etl_pkg::CLS_UNKNOWN;
          n_tok.token_start  = pos_r;
          n_tok.token_length = PW'(1);
        end
      end
    end

    if (adv && (pos_r < POS_CAP)) begin
      pos_nxt = pos_r + 1'b1;
    end
    if ((c == CH_NUL) && !f_v && (mode_r == MODE_IDLE)) begin
      pos_nxt = '0;
    end
    if ((c == CH_NUL) && f_v) begin
      pos_nxt = '0;
    end
  end

  // pack the flushed token ahead of the fresh one
  always_comb begin
    push_entry      = '0;
    if (f_v) begin
      push_entry.tok0 = f_tok;
      push_entry.tok1 = n_tok;
      push_entry.two  = n_v;
    end else begin
      push_entry.tok0 = n_tok;
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && (f_v || n_v);
  assign acc        = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      pfc_r   <= FC_EQ;
      kw_r    <= KW_EMPTY;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      pfc_r   <= pfc_nxt;
      kw_r    <= kw_nxt;
    end
  end

  a_stop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_char_code == CH_NUL)) |=> (pos_r == '0) && (mode_r == MODE_IDLE))
    else $error("end of expression did not rewind the position");

  a_start_behind_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_IDLE) |-> (start_r <= pos_r))
    else $error("pending token starts beyond the current position");

endmodule

/* hdl/etl_queue.sv */
// Short queue of token entries between the front end and the output stage.
// Depends on etl_pkg for the entry type and depth.
module etl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  etl_pkg::entry_t push_entry,
  output logic            push_ready,
  output logic            pop_valid,
  output etl_pkg::entry_t pop_entry,
  input  logic            pop_ready
);

  localparam int DEPTH = etl_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  etl_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r < CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue holds more entries than it has room for");

endmodule

/* hdl/etl_back.sv */
// Output stage: takes entries from the queue and delivers their tokens one per
// transfer through an output register, marking the last of each run. Depends on etl_pkg.
module etl_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  input  etl_pkg::entry_t             pop_entry,
  output logic                        pop_ready,
  output logic                        out_valid,
  output etl_pkg::tok_t               out_tok,
  output logic                        out_last,
  input  logic                        out_ready
);

  logic          out_valid_r;
  etl_pkg::tok_t out_tok_r;
  logic          out_last_r;
  logic          sec_valid_r;
  etl_pkg::tok_t sec_tok_r;
  logic          load;

  // output register free or emptying this cycle
  assign load      = !out_valid_r || out_ready;
  assign pop_ready = load && !sec_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (load) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else begin
        out_valid_r <= pop_valid;
        sec_valid_r <= pop_valid && pop_entry.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid_r) begin
        out_tok_r  <= sec_tok_r;
        out_last_r <= 1'b1;
      end else begin
        out_tok_r  <= pop_entry.tok0;
        out_last_r <= !pop_entry.two;
        sec_tok_r  <= pop_entry.tok1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;
  assign out_last  = out_last_r;

  a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> (out_valid_r && !out_last_r))
    else $error("second token held without its first token on the output");

endmodule

/* hdl/expression_token_lexer_unit.sv */
// Expression token lexer, top level. Ties the front end, the entry queue and the
// output stage to the two channels. Depends on etl_pkg and the etl channel interfaces.
//
// Characters of an expression arrive one per transfer on in_ch, code 0 ending the
// expression; tokens leave on out_ch, each with its class, operator character,
// compare code, and/or flag, start position and length, and last_of_run set on the
// final token caused by a character. A character is taken every cycle while the
// entry queue (four entries) has room; a character causes zero, one or two tokens
// and the output stage delivers at most one token per cycle. Only a character that
// closes a pending token and is itself a one-character token (or the stop code)
// causes two, and it leaves the lexer idle, so the character after it causes at most
// one; the queue absorbs the extra token and the sustained rate is one character per
// cycle while out_ch is ready. A token reaches out_ch through the queue register and
// then the output register. Positions and lengths saturate at
// min(MAX_EXPR_LEN - 1, 4095); after the stop token all lexer state returns to its
// reset values. No clearing pass after reset.
module expression_token_lexer_unit #(
  parameter int MAX_EXPR_LEN = etl_pkg::MAX_EXPR_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  etl_in_if.sink     in_ch,
  etl_out_if.source  out_ch
);

  logic            push_valid, push_ready;
  etl_pkg::entry_t push_entry;
  logic            pop_valid, pop_ready;
  etl_pkg::entry_t pop_entry;
  etl_pkg::tok_t   out_tok;
  logic            out_valid, out_last;

  // classify each character and form its tokens
  etl_front #(
    .MAX_EXPR_LEN (MAX_EXPR_LEN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_char_code (in_ch.char_code),
    .in_ready     (in_ch.ready),
    .push_valid   (push_valid),
    .push_entry   (push_entry),
    .push_ready   (push_ready)
  );

  // decouple the front end from output back-pressure
  etl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // serialise entries into single-token transfers
  etl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_valid (out_valid),
    .out_tok   (out_tok),
    .out_last  (out_last),
    .out_ready (out_ch.ready)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.token_class   = out_tok.token_class;
  assign out_ch.operator_char = out_tok.operator_char;
  assign out_ch.compare_code  = out_tok.compare_code;
  assign out_ch.logical_is_or = out_tok.logical_is_or;
  assign out_ch.token_start   = out_tok.token_start;
  assign out_ch.token_length  = out_tok.token_length;
  assign out_ch.last_of_run   = out_last;

endmodule
